// ===== hw/rtl/u8sd_pkg.sv =====
// u8sd_pkg: shared types and byte-class constants for the UTF-8 stream decoder.
// No dependencies; imported by u8sd_decode, u8sd_out_stage and utf8_stream_decoder.
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int CP_W  = 21;
    localparam int LEN_W = 3;

    // Byte classes: (byte & MASK) == PATTERN
    localparam logic [7:0] LEAD4_MASK = 8'b1111_1000;
    localparam logic [7:0] LEAD4_PAT  = 8'b1111_0000;
    localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
    localparam logic [7:0] LEAD3_PAT  = 8'b1110_0000;
    localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
    localparam logic [7:0] LEAD2_PAT  = 8'b1100_0000;
    localparam logic [7:0] CONT_MASK  = 8'b1100_0000;
    localparam logic [7:0] CONT_PAT   = 8'b1000_0000;

    // Payload masks
    localparam logic [7:0] CONT_BITS  = 8'h3f;
    localparam logic [7:0] LEAD4_BITS = 8'h07;
    localparam logic [7:0] LEAD3_BITS = 8'h0f;
    localparam logic [7:0] LEAD2_BITS = 8'h1f;
    localparam logic [7:0] ASCII_BITS = 8'h7f;

    // Sequence lengths
    localparam logic [LEN_W-1:0] LEN_ERR = 3'd0;
    localparam logic [LEN_W-1:0] LEN_1   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3   = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4   = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        logic             error;
        logic             match;
    } result_t;

endpackage

// ===== hw/rtl/u8sd_decode.sv =====
// u8sd_decode: sequence state, target register and per-byte decode logic.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [u8sd_pkg::CP_W-1:0] cfg_data,
    input  logic                   step,
    input  logic [7:0]             byte_in,
    output logic                   emit,
    output u8sd_pkg::result_t      result
);
    import u8sd_pkg::*;

    logic [1:0]       bytes_left_reg, bytes_left_next;
    logic [CP_W-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0] total_len_reg, total_len_next;
    logic [CP_W-1:0]  target_reg;

    logic             cont;
    logic [CP_W-1:0]  acc_shift;

    assign cont      = (byte_in & CONT_MASK) == CONT_PAT;
    assign acc_shift = {acc_reg[CP_W-7:0], byte_in[5:0] & CONT_BITS[5:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 2'd0;
            acc_reg        <= '0;
            total_len_reg  <= LEN_ERR;
            target_reg     <= '0;
        end
        else
        begin
            if (step)
            begin
                bytes_left_reg <= bytes_left_next;
                acc_reg        <= acc_next;
                total_len_reg  <= total_len_next;
            end
            if (cfg_we)
                target_reg <= cfg_data;
        end
    end

    always_comb
    begin
        bytes_left_next   = 2'd0;
        acc_next          = '0;
        total_len_next    = LEN_ERR;
        emit              = 1'b0;
        result.code_point = '0;
        result.seq_length = LEN_ERR;
        result.error      = 1'b0;

        if (bytes_left_reg != 2'd0)
        begin
            if (!cont)
            begin
                // bad continuation: byte dropped, back to idle
                emit         = 1'b1;
                result.error = 1'b1;
            end
            else if (bytes_left_reg == 2'd1)
            begin
                emit              = 1'b1;
                result.code_point = acc_shift;
                result.seq_length = total_len_reg;
            end
            else
            begin
                bytes_left_next = bytes_left_reg - 2'd1;
                acc_next        = acc_shift;
                total_len_next  = total_len_reg;
            end
        end
        else if ((byte_in & LEAD4_MASK) == LEAD4_PAT)
        begin
            bytes_left_next = 2'd3;
            acc_next        = {{(CP_W-8){1'b0}}, byte_in & LEAD4_BITS};
            total_len_next  = LEN_4;
        end
        else if ((byte_in & LEAD3_MASK) == LEAD3_PAT)
        begin
            bytes_left_next = 2'd2;
            acc_next        = {{(CP_W-8){1'b0}}, byte_in & LEAD3_BITS};
            total_len_next  = LEN_3;
        end
        else if ((byte_in & LEAD2_MASK) == LEAD2_PAT)
        begin
            bytes_left_next = 2'd1;
            acc_next        = {{(CP_W-8){1'b0}}, byte_in & LEAD2_BITS};
            total_len_next  = LEN_2;
        end
        else if (cont)
        begin
            // stray continuation
            emit         = 1'b1;
            result.error = 1'b1;
        end
        else
        begin
            emit              = 1'b1;
            result.code_point = {{(CP_W-8){1'b0}}, byte_in & ASCII_BITS};
            result.seq_length = LEN_1;
        end

        result.match = !result.error && (result.code_point == target_reg);
    end

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && result.error) |->
            (result.code_point == '0 && result.seq_length == LEN_ERR && !result.match))
        else $error("error result carries nonzero fields");

    a_len_vs_left: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg != 2'd0) |->
            (total_len_reg > {1'b0, bytes_left_reg} && total_len_reg <= LEN_4))
        else $error("sequence length inconsistent with bytes left");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg == 2'd0) |-> (acc_reg == '0 && total_len_reg == LEN_ERR))
        else $error("idle state not cleared");

    a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !result.error) |-> (result.seq_length != LEN_ERR))
        else $error("character result with zero length");
`endif

endmodule

// ===== hw/rtl/u8sd_out_stage.sv =====
// u8sd_out_stage: result register with valid/ready toward the consumer.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  u8sd_pkg::result_t   result_in,
    input  logic                out_ready,
    output logic                out_valid,
    output u8sd_pkg::result_t   result_out
);
    import u8sd_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_in;
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

// ===== hw/rtl/utf8_stream_decoder.sv =====
// utf8_stream_decoder: top level, input byte register feeding the decoder and result stage.
// Depends on u8sd_pkg, u8sd_decode, u8sd_out_stage.
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  -----------------------------------------
//  in       sink       in_valid / in_ready  in_byte[7:0]
//  out      source     out_valid/out_ready  code_point[20:0] seq_length[2:0] error match
//  cfg      sink       cfg_we (no wait)     cfg_data[20:0] -> target_char
//
// One byte per cycle sustained while out_ready does not stall; a character's last byte passes
// through the input register, then is decoded into the result register.
// Bytes that open or continue a sequence produce no output transaction.
// rst_n is asynchronous, active low: decoder idle, both stages empty, target_char = 0.
// A stall on out_ready holds the result register; the input register keeps
// accepting until it too is full, so in_ready drops only when both stages hold data.
`timescale 1ns / 1ps

module utf8_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [20:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [20:0] code_point,
    output logic [2:0]  seq_length,
    output logic        error,
    output logic        match
);
    import u8sd_pkg::*;

    // input register
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;

    logic    advance;       // stage-1 byte moves through the decoder this cycle
    logic    emit;
    result_t dec_result;
    result_t out_result;

    // decoder may step when the result slot is free or being drained
    assign advance  = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_byte_reg <= in_byte;
    end

    u8sd_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .step     (advance),
        .byte_in  (s1_byte_reg),
        .emit     (emit),
        .result   (dec_result)
    );

    u8sd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && emit),
        .result_in  (dec_result),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .result_out (out_result)
    );

    assign code_point = out_result.code_point;
    assign seq_length = out_result.seq_length;
    assign error      = out_result.error;
    assign match      = out_result.match;

`ifndef SYNTHESIS
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("stalled input byte lost");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid && !out_ready))
        else $error("in_ready low without a full pipeline");

    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted byte not captured");
`endif

endmodule
